[rtl/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, codes and constants of the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int HEAP_WORDS  = 1024;
    localparam int ADDR_W      = $clog2(HEAP_WORDS);
    localparam int OFF_W       = 12;
    localparam int SIZE_W      = 13;
    localparam int KIND_W      = 2;
    localparam int WORD_W      = 32;
    localparam int REGION_MIN  = 16;
    localparam int REGION_MAX  = (HEAP_WORDS * 4 > 4096) ? 4096 : HEAP_WORDS * 4;

    localparam logic [WORD_W-1:0] TERM_MARK   = 32'h0000_006B;
    localparam logic [WORD_W-1:0] SPLIT_SLACK = 32'd8;
    localparam logic [13:0]       TAG_BYTES   = 14'd8;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

endpackage

[rtl/ffba_if.sv]
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic                         valid;
    logic                         ready;
    logic [ffba_pkg::KIND_W-1:0]  kind;
    logic [ffba_pkg::SIZE_W-1:0]  request_size;
    logic [ffba_pkg::OFF_W-1:0]   block_offset;

    modport source (output valid, kind, request_size, block_offset, input ready);
    modport sink   (input valid, kind, request_size, block_offset, output ready);
endinterface

interface ffba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffba_pkg::OFF_W-1:0]   granted_offset;
    logic                         status;

    modport source (output valid, granted_offset, status, input ready);
    modport sink   (input valid, granted_offset, status, output ready);
endinterface

[rtl/first_fit_boundary_tag_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// First-fit heap allocator with boundary tags held in a word RAM (one write, one read port).
// ----------------------------------------------------------------------------
// Sequencing: allocate walks the blocks with one head-tag read each and writes
//   the tags on a grant; free reads the block and neighbour tags, then writes
//   the merged tags; check reads the block tags only; rejects answer from idle.
// Throughput: one request at a time; next accepted once the result is taken.
// Reset and region writes format the RAM in a pass over all HEAP_WORDS words, no
//   requests accepted meanwhile.
module first_fit_boundary_tag_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffba_pkg::SIZE_W-1:0] i_cfg_wdata,
    ffba_req_if.sink                    i_req,
    ffba_rsp_if.source                  o_rsp
);

    localparam int AW = ffba_pkg::ADDR_W;
    localparam int OW = ffba_pkg::OFF_W;
    localparam int WW = ffba_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_V_RD, S_V_EV, S_V_RD2, S_V_EV2,
        S_N_RD, S_N_EV, S_P_RD, S_P_EV, S_F_BUILD, S_WR
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_ci;
    logic [OW-1:0]     r_term;
    logic [ffba_pkg::KIND_W-1:0] r_kind;
    logic [13:0]       r_need;
    logic [OW-1:0]     r_off;
    logic [OW-1:0]     r_p;
    logic [OW-1:0]     r_cur;
    logic [OW-1:0]     r_nxt;
    logic [OW-1:0]     r_psz;
    logic [OW-1:0]     r_nsz;
    logic              r_pf;
    logic              r_nf;
    logic [OW-1:0]     r_wa [6];
    logic [WW-1:0]     r_wd [6];
    logic [5:0]        r_we;
    logic [2:0]        r_wi;
    logic              r_out_valid;
    logic [OW-1:0]     r_gr;
    logic              r_st;

    logic [WW-1:0]     mem [ffba_pkg::HEAP_WORDS];
    logic [WW-1:0]     mem_q;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WW-1:0]     mem_wd;
    logic [AW-1:0]     mem_ra;

    logic              accept;
    logic [WW-1:0]     q_neg;
    logic [WW-1:0]     q_size;
    logic              a_span;
    logic [OW-1:0]     a_next;
    logic              a_fit;
    logic [OW-1:0]     a_take;
    logic [WW-1:0]     a_rem;
    logic              v_ok;
    logic              n_ok;
    logic              p_ok;
    logic [OW-1:0]     f_start;
    logic [OW-1:0]     f_total;
    logic [OW-1:0]     c_term;
    logic [ffba_pkg::SIZE_W-1:0] c_reg;
    logic [AW-1:0]     clr_term_idx;

    function automatic logic span_ok(input logic [WW-1:0] s, input logic [OW-1:0] off,
                                     input logic [OW-1:0] lim);
        logic [OW-1:0] room;
        room = lim - off;
        return (s >= 32'd4) && (s[1:0] == 2'b00) && (s <= {{(WW-OW){1'b0}}, room});
    endfunction

    assign accept          = i_req.valid && i_req.ready;
    assign i_req.ready     = (r_state == S_IDLE) && !r_out_valid && !i_cfg_we;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.granted_offset = r_gr;
    assign o_rsp.status    = r_st;

    always_comb begin
        c_reg = i_cfg_wdata & ~ffba_pkg::SIZE_W'(3);
        if (c_reg < ffba_pkg::SIZE_W'(ffba_pkg::REGION_MIN)) begin
            c_reg = ffba_pkg::SIZE_W'(ffba_pkg::REGION_MIN);
        end else if (c_reg > ffba_pkg::SIZE_W'(ffba_pkg::REGION_MAX)) begin
            c_reg = ffba_pkg::SIZE_W'(ffba_pkg::REGION_MAX);
        end
        c_term = OW'(c_reg - ffba_pkg::SIZE_W'(4));
    end

    always_comb begin
        q_neg   = 32'd0 - mem_q;
        q_size  = mem_q[WW-1] ? q_neg : mem_q;
        a_span  = span_ok(q_size, r_off, r_term);
        a_next  = r_off + q_size[OW-1:0];
        a_fit   = !mem_q[WW-1] && (mem_q >= {{(WW-14){1'b0}}, r_need});
        a_rem   = mem_q - {{(WW-14){1'b0}}, r_need};
        a_take  = (a_rem <= ffba_pkg::SPLIT_SLACK) ? mem_q[OW-1:0] : r_need[OW-1:0];
        v_ok    = mem_q[WW-1] && span_ok(q_neg, r_p, r_term);
        n_ok    = !mem_q[WW-1] && (mem_q > 32'd2) && span_ok(mem_q, r_nxt, r_term);
        p_ok    = !mem_q[WW-1] && (mem_q > 32'd2) && span_ok(mem_q, '0, r_p);
        f_start = r_pf ? r_p - r_psz : r_p;
        f_total = (r_pf ? r_psz : '0) + r_cur + (r_nf ? r_nsz : '0);
    end

    assign clr_term_idx = r_term[AW+1:2];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ci;
        mem_wd = '0;
        mem_ra = r_off[AW+1:2];
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_ci == '0 || r_ci == clr_term_idx - AW'(1)) begin
                    mem_wd = {{(WW-OW){1'b0}}, r_term};
                end else if (r_ci == clr_term_idx) begin
                    mem_wd = ffba_pkg::TERM_MARK;
                end
            end
            S_WR: begin
                mem_we = r_we[r_wi];
                mem_wa = r_wa[r_wi][AW+1:2];
                mem_wd = r_wd[r_wi];
            end
            S_V_RD:  mem_ra = r_p[AW+1:2];
            S_V_RD2: mem_ra = r_p[AW+1:2] + AW'(1);
            S_N_RD:  mem_ra = r_nxt[AW+1:2];
            S_P_RD:  mem_ra = r_p[AW+1:2] - AW'(1);
            default: mem_ra = r_off[AW+1:2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ci        <= '0;
            r_term      <= OW'(ffba_pkg::REGION_MAX - 4);
            r_out_valid <= 1'b0;
            r_wi        <= '0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_cfg_we) begin
                        r_term <= c_term;
                        r_ci   <= '0;
                    end else begin
                        r_ci <= r_ci + AW'(1);
                        if (r_ci == AW'(ffba_pkg::HEAP_WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_term  <= c_term;
                        r_ci    <= '0;
                        r_state <= S_CLEAR;
                    end else if (accept) begin
                        r_kind <= i_req.kind;
                        r_p    <= i_req.block_offset;
                        r_off  <= '0;
                        r_need <= (({1'b0, i_req.request_size} + 14'd3) & ~14'd3)
                                  + ffba_pkg::TAG_BYTES;
                        r_gr   <= '0;
                        r_st   <= 1'b1;
                        if (i_req.kind == ffba_pkg::KIND_ALLOC) begin
                            if (i_req.request_size == '0) begin
                                r_out_valid <= 1'b1;
                            end else begin
                                r_state <= S_A_RD;
                            end
                        end else if (i_req.kind == ffba_pkg::KIND_FREE ||
                                     i_req.kind == ffba_pkg::KIND_CHECK) begin
                            if (i_req.block_offset[1:0] != 2'b00 ||
                                i_req.block_offset >= r_term) begin
                                r_out_valid <= 1'b1;
                            end else begin
                                r_state <= S_V_RD;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                S_A_RD: r_state <= S_A_EV;
                S_A_EV: begin
                    if (!a_span) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (a_fit) begin
                        r_wa[0] <= r_off;
                        r_wd[0] <= 32'd0 - {{(WW-OW){1'b0}}, a_take};
                        r_wa[1] <= r_off + a_take - OW'(4);
                        r_wd[1] <= 32'd0 - {{(WW-OW){1'b0}}, a_take};
                        r_wa[2] <= r_off + a_take;
                        r_wd[2] <= mem_q - {{(WW-OW){1'b0}}, a_take};
                        r_wa[3] <= r_off + mem_q[OW-1:0] - OW'(4);
                        r_wd[3] <= mem_q - {{(WW-OW){1'b0}}, a_take};
                        r_wa[4] <= '0;
                        r_wd[4] <= '0;
                        r_wa[5] <= '0;
                        r_wd[5] <= '0;
                        r_we    <= {2'b00, {2{a_take != mem_q[OW-1:0]}}, 2'b11};
                        r_wi    <= '0;
                        r_gr    <= r_off;
                        r_st    <= 1'b0;
                        r_state <= S_WR;
                    end else if (a_next >= r_term) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_off   <= a_next;
                        r_state <= S_A_RD;
                    end
                end
                S_V_RD: r_state <= S_V_EV;
                S_V_EV: begin
                    r_cur <= q_neg[OW-1:0];
                    r_nxt <= r_p + q_neg[OW-1:0];
                    if (!v_ok) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_V_RD2;
                    end
                end
                S_V_RD2: r_state <= S_V_EV2;
                S_V_EV2: begin
                    r_pf <= 1'b0;
                    r_nf <= 1'b0;
                    if (mem_q != '0) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_kind == ffba_pkg::KIND_CHECK) begin
                        r_st        <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (r_nxt < r_term) begin
                        r_state <= S_N_RD;
                    end else if (r_p != '0) begin
                        r_state <= S_P_RD;
                    end else begin
                        r_state <= S_F_BUILD;
                    end
                end
                S_N_RD: r_state <= S_N_EV;
                S_N_EV: begin
                    r_nf    <= n_ok;
                    r_nsz   <= mem_q[OW-1:0];
                    r_state <= (r_p != '0) ? S_P_RD : S_F_BUILD;
                end
                S_P_RD: r_state <= S_P_EV;
                S_P_EV: begin
                    r_pf    <= p_ok;
                    r_psz   <= mem_q[OW-1:0];
                    r_state <= S_F_BUILD;
                end
                S_F_BUILD: begin
                    r_wa[0] <= r_p - OW'(4);
                    r_wd[0] <= '0;
                    r_wa[1] <= r_p;
                    r_wd[1] <= '0;
                    r_wa[2] <= r_nxt - OW'(4);
                    r_wd[2] <= '0;
                    r_wa[3] <= r_nxt;
                    r_wd[3] <= '0;
                    r_wa[4] <= f_start;
                    r_wd[4] <= {{(WW-OW){1'b0}}, f_total};
                    r_wa[5] <= f_start + f_total - OW'(4);
                    r_wd[5] <= {{(WW-OW){1'b0}}, f_total};
                    r_we    <= {2'b11, r_nf, r_nf, r_pf, r_pf};
                    r_wi    <= '0;
                    r_st    <= 1'b0;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_wi <= r_wi + 3'd1;
                    if (r_wi == 3'd5) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
